FILE: design/i2c_master_bit_engine_top_macros.svh
// Assertion macros used by the I2C master bit engine top design file.
`ifndef I2C_MASTER_BIT_ENGINE_TOP_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define I2CMBE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define I2CMBE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/i2cmbe_pkg.sv
// Package with the types and constants of the I2C master bit engine.
`timescale 1ns / 1ps

package i2cmbe_pkg;

    localparam int TPU_W  = 10;
    localparam int TMO_W  = 8;
    localparam int DLY_W  = 12;
    localparam int BIT_W  = 4;
    localparam int BYTE_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [TPU_W-1:0] TICKS_PER_US_RST = 10'd48;
    localparam logic [TMO_W-1:0] ACK_TIMEOUT_RST  = 8'd250;
    localparam logic [BIT_W-1:0] BITS_PER_BYTE    = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TICKS_PER_US = 2'd0,
        REG_ACK_TIMEOUT  = 2'd1
    } t_reg_idx;

    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_START    = 3'd1,
        OP_STOP     = 3'd2,
        OP_WRITE    = 3'd3,
        OP_WAIT_ACK = 3'd4,
        OP_READ     = 3'd5
    } t_op;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_START_A = 4'd1,
        PH_START_B = 4'd2,
        PH_STOP_A  = 4'd3,
        PH_STOP_B  = 4'd4,
        PH_STOP_C  = 4'd5,
        PH_W_LOW   = 4'd6,
        PH_W_HIGH  = 4'd7,
        PH_W_TAIL  = 4'd8,
        PH_A_REL   = 4'd9,
        PH_A_HIGH  = 4'd10,
        PH_A_POLL  = 4'd11,
        PH_R_LOW   = 4'd12,
        PH_R_HIGH  = 4'd13,
        PH_K_LOW   = 4'd14,
        PH_K_HIGH  = 4'd15
    } t_phase;

    typedef struct packed {
        logic [TPU_W-1:0] ticks_per_us;
        logic [TMO_W-1:0] ack_timeout;
    } t_cfg;

    typedef struct packed {
        logic [2:0]        op;
        logic [BYTE_W-1:0] wdata;
        logic              send_ack;
        logic              sda_in;
    } t_item;

    typedef struct packed {
        logic              scl;
        logic              sda_drive;
        logic              sda_oe;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] rdata;
        logic              ack_fail;
    } t_result;

endpackage

FILE: design/i2cmbe_ifs.sv
// Channel interfaces of the I2C master bit engine: input, result and configuration.
`timescale 1ns / 1ps

interface i2cmbe_in_if;
    import i2cmbe_pkg::*;
    logic              valid;
    logic              ready;
    logic [2:0]        op;
    logic [BYTE_W-1:0] wdata;
    logic              send_ack;
    logic              sda_in;
    modport source (output valid, op, wdata, send_ack, sda_in, input ready);
    modport sink   (input valid, op, wdata, send_ack, sda_in, output ready);
endinterface

interface i2cmbe_out_if;
    import i2cmbe_pkg::*;
    logic              valid;
    logic              ready;
    logic              scl;
    logic              sda_drive;
    logic              sda_oe;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] rdata;
    logic              ack_fail;
    modport source (output valid, scl, sda_drive, sda_oe, busy_res, done_res, rdata,
                    ack_fail, input ready);
    modport sink   (input valid, scl, sda_drive, sda_oe, busy_res, done_res, rdata,
                    ack_fail, output ready);
endinterface

interface i2cmbe_cfg_if;
    import i2cmbe_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/i2cmbe_cfg_regs.sv
// Configuration registers of the I2C master bit engine.
`timescale 1ns / 1ps

module i2cmbe_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    i2cmbe_cfg_if.sink        i_cfg,
    output i2cmbe_pkg::t_cfg  o_cfg
);
    import i2cmbe_pkg::*;

    logic [TPU_W-1:0] r_ticks_per_us;
    logic [TMO_W-1:0] r_ack_timeout;

    // Writes are always taken.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_us <= TICKS_PER_US_RST;
            r_ack_timeout  <= ACK_TIMEOUT_RST;
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_TICKS_PER_US: begin
                    r_ticks_per_us <= i_cfg.data[TPU_W-1:0];
                end
                REG_ACK_TIMEOUT: begin
                    r_ack_timeout <= i_cfg.data[TMO_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.ticks_per_us = r_ticks_per_us;
    assign o_cfg.ack_timeout  = r_ack_timeout;

endmodule

FILE: design/i2cmbe_core.sv
// Bus sequencing state machine of the I2C master bit engine, one tick per step.
`timescale 1ns / 1ps

module i2cmbe_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  i2cmbe_pkg::t_item   i_item,
    input  i2cmbe_pkg::t_cfg    i_cfg,
    output i2cmbe_pkg::t_result o_res
);
    import i2cmbe_pkg::*;

    t_phase            r_phase, n_phase;
    logic [BIT_W-1:0]  r_bit, n_bit;
    logic [BYTE_W-1:0] r_shift, n_shift;
    logic [DLY_W-1:0]  r_delay, n_delay;
    logic [TMO_W-1:0]  r_timeout, n_timeout;
    logic              r_scl, n_scl;
    logic              r_sda, n_sda;
    logic              r_sda_en, n_sda_en;
    logic              r_ack_missing, n_ack_missing;
    logic              r_ack_choice, n_ack_choice;
    logic [BYTE_W-1:0] r_rx, n_rx;
    logic              n_done;

    logic [TPU_W-1:0]  tpu;
    logic [DLY_W-1:0]  hold_1us, hold_2us, hold_4us;
    logic [DLY_W-1:0]  delay_dec;
    logic [TMO_W:0]    timeout_inc;
    logic [BIT_W-1:0]  bit_inc;
    logic [BYTE_W-1:0] shift_left;

    // A zero tick count behaves as one tick; 4 x 1023 still fits the counter.
    assign tpu       = (i_cfg.ticks_per_us == '0) ? TPU_W'(1) : i_cfg.ticks_per_us;
    assign hold_1us  = DLY_W'(tpu);
    assign hold_2us  = DLY_W'({tpu, 1'b0});
    assign hold_4us  = DLY_W'({tpu, 2'b00});
    assign delay_dec = (r_delay != '0) ? r_delay - DLY_W'(1) : '0;
    assign timeout_inc = {1'b0, r_timeout} + (TMO_W+1)'(1);
    assign bit_inc     = r_bit + BIT_W'(1);
    assign shift_left  = {r_shift[BYTE_W-2:0], 1'b0};

    always_comb begin
        n_phase       = r_phase;
        n_bit         = r_bit;
        n_shift       = r_shift;
        n_delay       = r_delay;
        n_timeout     = r_timeout;
        n_scl         = r_scl;
        n_sda         = r_sda;
        n_sda_en      = r_sda_en;
        n_ack_missing = r_ack_missing;
        n_ack_choice  = r_ack_choice;
        n_rx          = r_rx;
        n_done        = 1'b0;

        if (r_phase == PH_IDLE) begin
            case (t_op'(i_item.op))
                OP_START: begin
                    n_sda_en = 1'b1;
                    n_sda    = 1'b1;
                    n_scl    = 1'b1;
                    n_phase  = PH_START_A;
                    n_delay  = hold_4us;
                end
                OP_STOP: begin
                    n_sda_en = 1'b1;
                    n_scl    = 1'b0;
                    n_sda    = 1'b0;
                    n_phase  = PH_STOP_A;
                    n_delay  = hold_4us;
                end
                OP_WRITE: begin
                    n_sda_en = 1'b1;
                    n_scl    = 1'b0;
                    n_shift  = i_item.wdata;
                    n_bit    = '0;
                    n_sda    = i_item.wdata[BYTE_W-1];
                    n_phase  = PH_W_LOW;
                    n_delay  = hold_2us;
                end
                OP_WAIT_ACK: begin
                    n_sda_en      = 1'b0;
                    n_sda         = 1'b1;
                    n_timeout     = '0;
                    n_ack_missing = 1'b0;
                    n_phase       = PH_A_REL;
                    n_delay       = hold_1us;
                end
                OP_READ: begin
                    n_sda_en     = 1'b0;
                    n_scl        = 1'b0;
                    n_ack_choice = i_item.send_ack;
                    n_shift      = '0;
                    n_bit        = '0;
                    n_phase      = PH_R_LOW;
                    n_delay      = hold_2us;
                end
                default: begin
                end
            endcase
        end else if (r_phase == PH_A_POLL) begin
            if (!i_item.sda_in) begin
                n_scl   = 1'b0;
                n_phase = PH_IDLE;
                n_done  = 1'b1;
            end else if (timeout_inc > {1'b0, i_cfg.ack_timeout}) begin
                // No acknowledge in time: flag it and release the bus with a stop.
                n_ack_missing = 1'b1;
                n_timeout     = '0;
                n_sda_en      = 1'b1;
                n_scl         = 1'b0;
                n_sda         = 1'b0;
                n_phase       = PH_STOP_A;
                n_delay       = hold_4us;
            end else begin
                n_timeout = timeout_inc[TMO_W-1:0];
            end
        end else begin
            n_delay = delay_dec;
            if (delay_dec == '0) begin
                case (r_phase)
                    PH_START_A: begin
                        n_sda   = 1'b0;
                        n_phase = PH_START_B;
                        n_delay = hold_4us;
                    end
                    PH_START_B: begin
                        n_scl   = 1'b0;
                        n_phase = PH_IDLE;
                        n_done  = 1'b1;
                    end
                    PH_STOP_A: begin
                        n_scl   = 1'b1;
                        n_phase = PH_STOP_B;
                        n_delay = hold_4us;
                    end
                    PH_STOP_B: begin
                        n_sda   = 1'b1;
                        n_phase = PH_STOP_C;
                        n_delay = hold_4us;
                    end
                    PH_STOP_C: begin
                        n_phase = PH_IDLE;
                        n_done  = 1'b1;
                    end
                    PH_W_LOW: begin
                        n_scl   = 1'b1;
                        n_phase = PH_W_HIGH;
                        n_delay = hold_2us;
                    end
                    PH_W_HIGH: begin
                        n_scl   = 1'b0;
                        n_phase = PH_W_TAIL;
                        n_delay = hold_2us;
                    end
                    PH_W_TAIL: begin
                        n_shift = shift_left;
                        n_bit   = bit_inc;
                        if (bit_inc >= BITS_PER_BYTE) begin
                            n_phase = PH_IDLE;
                            n_done  = 1'b1;
                        end else begin
                            n_sda   = shift_left[BYTE_W-1];
                            n_phase = PH_W_LOW;
                            n_delay = hold_2us;
                        end
                    end
                    PH_A_REL: begin
                        n_scl   = 1'b1;
                        n_phase = PH_A_HIGH;
                        n_delay = hold_1us;
                    end
                    PH_A_HIGH: begin
                        n_phase = PH_A_POLL;
                        n_delay = '0;
                    end
                    PH_R_LOW: begin
                        n_scl   = 1'b1;
                        n_shift = {r_shift[BYTE_W-2:0], i_item.sda_in};
                        n_phase = PH_R_HIGH;
                        n_delay = hold_1us;
                    end
                    PH_R_HIGH: begin
                        n_bit = bit_inc;
                        n_scl = 1'b0;
                        if (bit_inc >= BITS_PER_BYTE) begin
                            n_rx     = r_shift;
                            n_sda_en = 1'b1;
                            n_sda    = !r_ack_choice;
                            n_phase  = PH_K_LOW;
                        end else begin
                            n_phase = PH_R_LOW;
                        end
                        n_delay = hold_2us;
                    end
                    PH_K_LOW: begin
                        n_scl   = 1'b1;
                        n_phase = PH_K_HIGH;
                        n_delay = hold_2us;
                    end
                    PH_K_HIGH: begin
                        n_scl   = 1'b0;
                        n_phase = PH_IDLE;
                        n_done  = 1'b1;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_bit         <= '0;
            r_shift       <= '0;
            r_delay       <= '0;
            r_timeout     <= '0;
            r_scl         <= 1'b1;
            r_sda         <= 1'b1;
            r_sda_en      <= 1'b1;
            r_ack_missing <= 1'b0;
            r_ack_choice  <= 1'b0;
            r_rx          <= '0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_bit         <= n_bit;
            r_shift       <= n_shift;
            r_delay       <= n_delay;
            r_timeout     <= n_timeout;
            r_scl         <= n_scl;
            r_sda         <= n_sda;
            r_sda_en      <= n_sda_en;
            r_ack_missing <= n_ack_missing;
            r_ack_choice  <= n_ack_choice;
            r_rx          <= n_rx;
        end
    end

    assign o_res.scl       = n_scl;
    assign o_res.sda_drive = n_sda;
    assign o_res.sda_oe    = n_sda_en;
    assign o_res.busy_res  = (n_phase != PH_IDLE);
    assign o_res.done_res  = n_done;
    assign o_res.rdata     = n_rx;
    assign o_res.ack_fail  = n_ack_missing;

endmodule

FILE: design/i2c_master_bit_engine_top.sv
// An accepted item is held in the input register until the result register has room; then
// its result item is loaded there. Throughput: one item per cycle while results are taken;
// the bus state machine advances once per item between the input and result registers.
// Reset (i_rst_n low at a rising edge) empties both registers, returns the bus
// to idle with SCL and SDA high and driven, and loads the default configuration.
`timescale 1ns / 1ps

`include "i2c_master_bit_engine_top_macros.svh"

module i2c_master_bit_engine_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    i2cmbe_in_if.sink     i_in,
    i2cmbe_cfg_if.sink    i_cfg,
    i2cmbe_out_if.source  o_out
);
    import i2cmbe_pkg::*;

    // Each input item is one tick of bus timing. The item is first captured in
    // an input register; from there the state machine consumes it, and the resulting bus
    // levels and status land in the result register.
    // Either register moves on as soon as the stage after it has room, so items
    // stream through at one per cycle when the result side keeps taking them.

    t_cfg    w_cfg;
    t_result w_res;
    t_item   r_in;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;
    logic    w_advance;
    logic    w_step;

    // The result register is free when it is empty or being taken this cycle.
    assign w_advance  = !r_out_valid || o_out.ready;
    assign w_step     = r_in_valid && w_advance;
    assign i_in.ready = !r_in_valid || w_advance;

    i2cmbe_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    i2cmbe_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_item  (r_in),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    // Input register: control state is reset, the payload is only loaded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.op       <= i_in.op;
            r_in.wdata    <= i_in.wdata;
            r_in.send_ack <= i_in.send_ack;
            r_in.sda_in   <= i_in.sda_in;
        end
    end

    // Result register: holds one result item until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.scl       = r_out.scl;
    assign o_out.sda_drive = r_out.sda_drive;
    assign o_out.sda_oe    = r_out.sda_oe;
    assign o_out.busy_res  = r_out.busy_res;
    assign o_out.done_res  = r_out.done_res;
    assign o_out.rdata     = r_out.rdata;
    assign o_out.ack_fail  = r_out.ack_fail;

    // A completed command always leaves the engine idle.
    `I2CMBE_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, r_out_valid && r_out.done_res, !r_out.busy_res, "done result while still busy")

    // A held input item is never dropped while the result side stalls.
    `I2CMBE_ASSERT_NEXT(a_in_kept, i_clk, i_rst_n, r_in_valid && !w_advance, r_in_valid, "stalled input item lost")

    // Every item consumed by the state machine shows up in the result register.
    `I2CMBE_ASSERT_NEXT(a_step_out, i_clk, i_rst_n, w_step, r_out_valid, "consumed item produced no result")

endmodule
